// ===== rtl/womr_pkg.sv =====
// Shared types, codes and size constants of the write-only ORAM remap core.
package womr_pkg;

    localparam int DEF_MAX_MAIN = 1024;
    localparam int DEF_MAX_HOLD = 1024;
    localparam int SLOT_W       = 11;
    localparam int PAGE_W       = 27;
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int MAX_COPIES   = 63;

    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_SLOTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SLOTS = 2'd1;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [1:0] RK_PLACE = 2'd0;
    localparam logic [1:0] RK_COPY  = 2'd1;
    localparam logic [1:0] RK_READ  = 2'd2;
    localparam logic [1:0] RK_ERROR = 2'd3;

    localparam logic [1:0] CLS_WRITE = 2'd0;
    localparam logic [1:0] CLS_READ  = 2'd1;
    localparam logic [1:0] CLS_ERROR = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [PAGE_W-1:0] page_number;
    } req_t;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] source_slot;
        logic              last;
    } rsp_t;

    // Classified request as it waits between the front and back ends.
    typedef struct packed {
        logic [1:0]        cls;
        logic [PAGE_W-1:0] page;
    } cmd_t;

endpackage

// ===== rtl/womr_front.sv =====
// Front end: accepts requests and classifies them as write, read or out-of-range.
module womr_front #(
    parameter int NW = 11
) (
    input  logic            s_valid,
    output logic            s_ready,
    input  womr_pkg::req_t  s_data,
    input  logic [NW-1:0]   n_eff,
    input  logic            back_ready,
    input  logic            q_ready,
    output logic            q_valid,
    output womr_pkg::cmd_t  q_data
);
    import womr_pkg::*;

    logic out_of_range;

    assign out_of_range = 32'(s_data.page_number) >= 32'(n_eff);
    assign s_ready      = q_ready && back_ready;
    assign q_valid      = s_valid && back_ready;

    always_comb begin
        q_data.page = s_data.page_number;
        if (out_of_range) begin
            q_data.cls = CLS_ERROR;
        end else if (s_data.kind == KIND_READ) begin
            q_data.cls = CLS_READ;
        end else begin
            q_data.cls = CLS_WRITE;
        end
    end
endmodule

// ===== rtl/womr_queue.sv =====
// Two-entry request queue between the front and back ends.
module womr_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  womr_pkg::cmd_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output womr_pkg::cmd_t  out_data
);
    import womr_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end
endmodule

// ===== rtl/womr_div.sv =====
// Restoring divider, one quotient bit per cycle.
module womr_div #(
    parameter int DW = 21,
    parameter int HW = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [HW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [HW-1:0] remainder
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [HW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [HW:0]   trial;
    logic          fits;

    assign trial     = {rem_reg, quo_reg[DW-1]};
    assign fits      = trial >= {1'b0, divisor};
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CW'(DW);
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_reg - CW'(1);
                done_reg <= cnt_reg == CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? HW'(trial - {1'b0, divisor}) : trial[HW-1:0];
        end
    end
endmodule

// ===== rtl/womr_back.sv =====
// Back end: position map, write phase, refresh sequencing and result register.
module womr_back #(
    parameter int MAX_MAIN = 1024,
    parameter int MAX_HOLD = 1024,
    parameter int NW  = 11,
    parameter int IW  = 10,
    parameter int HW  = 11,
    parameter int PHW = 10
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [NW-1:0]   n_eff,
    input  logic [HW-1:0]   m_eff,
    output logic            ready,
    input  logic            q_valid,
    output logic            q_ready,
    input  womr_pkg::cmd_t  q_data,
    output logic            m_valid,
    input  logic            m_ready,
    output womr_pkg::rsp_t  m_data
);
    import womr_pkg::*;

    localparam int DW = PHW + NW;

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_RD_OUT = 4'd2;
    localparam logic [3:0] ST_ERR    = 4'd3;
    localparam logic [3:0] ST_GO_C   = 4'd4;
    localparam logic [3:0] ST_DIV_C  = 4'd5;
    localparam logic [3:0] ST_MUL_S  = 4'd6;
    localparam logic [3:0] ST_GO_S   = 4'd7;
    localparam logic [3:0] ST_DIV_S  = 4'd8;
    localparam logic [3:0] ST_MUL_E  = 4'd9;
    localparam logic [3:0] ST_GO_E   = 4'd10;
    localparam logic [3:0] ST_DIV_E  = 4'd11;
    localparam logic [3:0] ST_CHK    = 4'd12;
    localparam logic [3:0] ST_PLACE  = 4'd13;
    localparam logic [3:0] ST_CP_RD  = 4'd14;
    localparam logic [3:0] ST_CP_OUT = 4'd15;

    logic [SLOT_W-1:0] map_mem [MAX_MAIN];
    logic [SLOT_W-1:0] rdata_reg;

    logic [3:0]     state_reg, state_next;
    logic [IW-1:0]  clr_reg;
    logic [IW-1:0]  page_reg;
    logic [PHW-1:0] phase_reg, c_reg;
    logic [DW-1:0]  prod_reg;
    logic [NW-1:0]  start_reg, end_reg, a_reg;
    logic           out_valid_reg;
    rsp_t           out_reg;

    logic           out_free;
    logic           last_phase;
    logic           div_start, div_done;
    logic [DW-1:0]  div_quo;
    logic [HW-1:0]  div_rem;
    logic [IW-1:0]  raddr;
    logic [SLOT_W-1:0] hold_slot;

    assign out_free   = !out_valid_reg || m_ready;
    assign last_phase = 32'(c_reg) + 32'd1 == 32'(m_eff);
    assign hold_slot  = SLOT_W'(32'(n_eff) + 32'(c_reg));
    assign div_start  = state_reg == ST_GO_C || state_reg == ST_GO_S || state_reg == ST_GO_E;
    assign ready      = state_reg != ST_CLEAR;
    assign q_ready    = state_reg == ST_IDLE;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_reg;
    assign raddr      = (state_reg == ST_IDLE) ? q_data.page[IW-1:0]
                      : (state_reg == ST_CP_RD || state_reg == ST_CP_OUT) ? a_reg[IW-1:0]
                      : page_reg;

    womr_div #(.DW(DW), .HW(HW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (prod_reg),
        .divisor   (m_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (32'(clr_reg) == 32'(MAX_MAIN - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_data.cls == CLS_ERROR) begin
                        state_next = ST_ERR;
                    end else if (q_data.cls == CLS_READ) begin
                        state_next = ST_RD_OUT;
                    end else if (32'(phase_reg) < 32'(m_eff)) begin
                        state_next = ST_MUL_S;
                    end else begin
                        state_next = ST_GO_C;
                    end
                end
            end
            ST_RD_OUT: if (out_free) state_next = ST_IDLE;
            ST_ERR:    if (out_free) state_next = ST_IDLE;
            ST_GO_C:   state_next = ST_DIV_C;
            ST_DIV_C:  if (div_done) state_next = ST_MUL_S;
            ST_MUL_S:  state_next = ST_GO_S;
            ST_GO_S:   state_next = ST_DIV_S;
            ST_DIV_S: begin
                if (div_done) begin
                    state_next = last_phase ? ST_CHK : ST_MUL_E;
                end
            end
            ST_MUL_E:  state_next = ST_GO_E;
            ST_GO_E:   state_next = ST_DIV_E;
            ST_DIV_E:  if (div_done) state_next = ST_CHK;
            ST_CHK: begin
                if (32'(end_reg) - 32'(start_reg) > 32'(MAX_COPIES)) begin
                    state_next = ST_ERR;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                if (out_free) begin
                    state_next = (start_reg == end_reg) ? ST_IDLE : ST_CP_RD;
                end
            end
            ST_CP_RD:  state_next = ST_CP_OUT;
            ST_CP_OUT: begin
                if (out_free) begin
                    state_next = (32'(a_reg) + 32'd1 == 32'(end_reg)) ? ST_IDLE : ST_CP_RD;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + IW'(1);
            end
            if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (out_free && (state_reg == ST_RD_OUT || state_reg == ST_ERR ||
                             state_reg == ST_PLACE || state_reg == ST_CP_OUT)) begin
                out_valid_reg <= 1'b1;
            end
            // The phase advances once the placement is committed.
            if (state_reg == ST_PLACE && out_free) begin
                phase_reg <= last_phase ? '0 : c_reg + PHW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= map_mem[raddr];
        if (state_reg == ST_CLEAR) begin
            map_mem[clr_reg] <= SLOT_W'(clr_reg);
        end else if (state_reg == ST_PLACE && out_free) begin
            map_mem[page_reg] <= hold_slot;
        end else if (state_reg == ST_CP_OUT && out_free) begin
            map_mem[a_reg[IW-1:0]] <= SLOT_W'(a_reg);
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                page_reg <= q_data.page[IW-1:0];
                c_reg    <= phase_reg;
                prod_reg <= DW'(phase_reg);
            end
            ST_DIV_C: if (div_done) c_reg <= PHW'(div_rem);
            ST_MUL_S: prod_reg <= DW'(c_reg) * DW'(n_eff);
            ST_DIV_S: begin
                if (div_done) begin
                    start_reg <= NW'(div_quo);
                    end_reg   <= n_eff;
                end
            end
            ST_MUL_E: prod_reg <= (DW'(c_reg) + DW'(1)) * DW'(n_eff);
            ST_DIV_E: if (div_done) end_reg <= NW'(div_quo);
            ST_PLACE: a_reg <= start_reg;
            ST_CP_OUT: if (out_free) a_reg <= a_reg + NW'(1);
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            case (state_reg)
                ST_RD_OUT: out_reg <= '{RK_READ, rdata_reg, '0, 1'b1};
                ST_ERR:    out_reg <= '{RK_ERROR, '0, '0, 1'b1};
                ST_PLACE:  out_reg <= '{RK_PLACE, hold_slot, '0, start_reg == end_reg};
                ST_CP_OUT: out_reg <= '{RK_COPY, SLOT_W'(a_reg), rdata_reg,
                                        32'(a_reg) + 32'd1 == 32'(end_reg)};
                default: begin
                end
            endcase
        end
    end
endmodule

// ===== rtl/write_only_oram_remap_core.sv =====
// Top level of the write-only ORAM position-map remap core.
//
// Requests arrive on the s_ channel (kind, page_number) and results leave on
// the m_ channel; both use valid/ready. A read gives one result with the map
// entry. A write gives a placement result followed by one copy result per
// refreshed main-area address, the last one flagged. A write spends one to
// three runs of the shared restoring divider, then a read state and an output
// state per copy; one request is worked on at a time in the back end while the
// front end and a two-entry queue keep accepting requests until it is full.
// An out-of-range page or an over-long refresh gives one error result.
// After reset the map is swept to the identity, one entry per cycle over all
// MAX_MAIN entries, and s_ready stays low during that sweep; configuration
// writes are taken at any time. When the receiver holds m_ready low the
// result register keeps its item and the back end waits on it.
module write_only_oram_remap_core #(
    parameter int MAX_MAIN = womr_pkg::DEF_MAX_MAIN,
    parameter int MAX_HOLD = womr_pkg::DEF_MAX_HOLD
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  womr_pkg::req_t                       s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output womr_pkg::rsp_t                       m_data,
    input  logic                                 cfg_we,
    input  logic [womr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [womr_pkg::CFG_W-1:0]           cfg_wdata
);
    import womr_pkg::*;

    localparam int NW  = $clog2(MAX_MAIN + 1);
    localparam int IW  = $clog2(MAX_MAIN);
    localparam int HW  = $clog2(MAX_HOLD + 1);
    localparam int PHW = (MAX_HOLD > 1) ? $clog2(MAX_HOLD) : 1;

    logic [CFG_W-1:0] main_slots_reg, holding_slots_reg;
    logic [31:0]      n32, m32;
    logic [NW-1:0]    n_eff;
    logic [HW-1:0]    m_eff;
    logic             back_ready;
    logic             fq_valid, fq_ready, qb_valid, qb_ready;
    cmd_t             fq_data, qb_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_slots_reg    <= CFG_W'(512);
            holding_slots_reg <= CFG_W'(512);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MAIN_SLOTS: main_slots_reg    <= cfg_wdata;
                CFG_HOLD_SLOTS: holding_slots_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n32 = (32'(main_slots_reg) > 32'(MAX_MAIN)) ? 32'(MAX_MAIN) : 32'(main_slots_reg);
        m32 = (holding_slots_reg == '0) ? 32'd1 : 32'(holding_slots_reg);
        if (m32 > 32'(MAX_HOLD)) begin
            m32 = 32'(MAX_HOLD);
        end
    end

    assign n_eff = n32[NW-1:0];
    assign m_eff = m32[HW-1:0];

    womr_front #(.NW(NW)) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .n_eff      (n_eff),
        .back_ready (back_ready),
        .q_ready    (fq_ready),
        .q_valid    (fq_valid),
        .q_data     (fq_data)
    );

    womr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    womr_back #(
        .MAX_MAIN (MAX_MAIN),
        .MAX_HOLD (MAX_HOLD),
        .NW       (NW),
        .IW       (IW),
        .HW       (HW),
        .PHW      (PHW)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .n_eff   (n_eff),
        .m_eff   (m_eff),
        .ready   (back_ready),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );
endmodule
